// ===== hdl/pps_pkg.sv =====
// Shared types and constants of the playlist playback sequencer.
// Holds the beat structs, the command and play enums and the control structs.
// Depends on nothing; the RTL files refer to it by scoped names, the testbench imports it.
package pps_pkg;

  localparam int unsigned MaxSongs    = 256;
  localparam int unsigned CountWidth  = 9;
  localparam int unsigned SeedWidth   = 32;

  localparam logic [SeedWidth-1:0] LcgMul    = 32'd1664525;
  localparam logic [SeedWidth-1:0] LcgInc    = 32'd1013904223;
  localparam logic [SeedWidth-1:0] SeedReset = 32'h12345678;

  localparam logic [6:0] VolumeMax   = 7'd100;
  localparam logic [6:0] VolumeReset = 7'd60;

  typedef enum logic [1:0] {
    PlayIdle    = 2'd0,
    PlayPlaying = 2'd1,
    PlayPaused  = 2'd2,
    PlayStopped = 2'd3
  } play_state_e;

  typedef enum logic [1:0] {
    ModeSeq     = 2'd0,
    ModeLoopAll = 2'd1,
    ModeLoopOne = 2'd2,
    ModeShuffle = 2'd3
  } play_mode_e;

  typedef enum logic [2:0] {
    CmdTick    = 3'd0,
    CmdPlay    = 3'd1,
    CmdToggle  = 3'd2,
    CmdNext    = 3'd3,
    CmdPrev    = 3'd4,
    CmdCycle   = 3'd5,
    CmdVolume  = 3'd6,
    CmdLoadDur = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  song_index;
    logic [15:0] duration_value;
    logic [7:0]  volume_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  play_state;
    logic [1:0]  play_mode;
    logic [7:0]  current_index;
    logic [15:0] position;
    logic [15:0] current_duration;
    logic [6:0]  volume;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic lcg;
    logic div_start;
    logic jump;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_rand;
    logic need_mod;
    logic div_busy;
  } dp_status_t;

endpackage

// ===== hdl/pps_div.sv =====
// Iterative restoring divider that returns the remainder of a 32-bit value
// by a 9-bit song count, one quotient bit per cycle.
// Depends on pps_pkg for the operand widths.
module pps_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pps_pkg::SeedWidth-1:0]     dividend_i,
  input  logic [pps_pkg::CountWidth-1:0]    divisor_i,
  output logic                              busy_o,
  output logic [pps_pkg::CountWidth-1:0]    rem_o
);

  localparam int unsigned NumWidth  = pps_pkg::SeedWidth;
  localparam int unsigned DenWidth  = pps_pkg::CountWidth;
  localparam int unsigned StepWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0]  num_q;
  logic [DenWidth-1:0]  rem_q;
  logic [DenWidth-1:0]  den_q;
  logic [StepWidth-1:0] step_q;
  logic [DenWidth:0]    partial;
  logic [DenWidth:0]    diff;
  logic                 fits;

  assign partial = {rem_q, num_q[NumWidth-1]};
  assign fits    = partial >= {1'b0, den_q};
  assign diff    = partial - {1'b0, den_q};
  assign busy_o  = step_q != '0;
  assign rem_o   = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepWidth'(NumWidth);
    end else if (busy_o) begin
      step_q <= step_q - StepWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_o) begin
      num_q <= {num_q[NumWidth-2:0], 1'b0};
      rem_q <= fits ? diff[DenWidth-1:0] : partial[DenWidth-1:0];
    end
  end

endmodule

// ===== hdl/pps_dp.sv =====
// Datapath of the playlist playback sequencer: play registers, shuffle seed,
// duration memory, song count register, output register and the divider.
// Depends on pps_pkg and pps_div; driven by pps_ctrl through ctrl_cmd_t.
module pps_dp #(
  parameter int unsigned NUM_SLOTS = pps_pkg::MaxSongs
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pps_pkg::CountWidth-1:0] cfg_wdata_i,
  input  pps_pkg::in_beat_t              in_beat_i,
  input  pps_pkg::ctrl_cmd_t             cmd_i,
  output pps_pkg::dp_status_t            status_o,
  output pps_pkg::out_beat_t             out_beat_o
);

  localparam int unsigned AddrWidth = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW      = pps_pkg::CountWidth;
  localparam logic [CntW-1:0] MaxCount = CntW'(NUM_SLOTS);

  logic [CntW-1:0]               count_q;
  pps_pkg::play_state_e          st_q, st_d;
  pps_pkg::play_mode_e           mode_q, mode_d;
  logic [7:0]                    idx_q, idx_d;
  logic [15:0]                   pos_q, pos_d;
  logic [6:0]                    vol_q, vol_d;
  logic [pps_pkg::SeedWidth-1:0] seed_q, seed_d;
  logic [pps_pkg::SeedWidth-1:0] div_src_q, div_src_d;
  logic [pps_pkg::SeedWidth-1:0] lcg_next;
  pps_pkg::in_beat_t             cmd_q;
  pps_pkg::out_beat_t            out_q;
  logic [15:0]                   dur_mem [NUM_SLOTS];
  logic [15:0]                   rdata_q;

  logic [CntW-1:0] cnt, cnt_m1, idx9, inc9, dec9, jump_tgt, div_rem;
  logic [15:0]     pos_inc;
  logic            empty, tick_go, song_end, jump_en, mem_we, div_busy;
  pps_pkg::cmd_e   op;

  function automatic logic [7:0] clamp_idx(input logic [CntW-1:0] target,
                                           input logic [CntW-1:0] limit);
    logic [CntW-1:0] r;
    r = (target >= limit) ? limit - CntW'(1) : target;
    return r[7:0];
  endfunction

  assign cnt      = (count_q > MaxCount) ? MaxCount : count_q;
  assign empty    = cnt == '0;
  assign cnt_m1   = cnt - CntW'(1);
  assign idx9     = {1'b0, idx_q};
  assign inc9     = idx9 + CntW'(1);
  assign dec9     = idx9 - CntW'(1);
  assign op       = pps_pkg::cmd_e'(cmd_q.mode);
  assign pos_inc  = (pos_q < rdata_q) ? pos_q + 16'd1 : pos_q;
  assign song_end = pos_inc >= rdata_q;
  assign tick_go  = !empty && (st_q == pps_pkg::PlayPlaying) && (rdata_q != 16'd0);
  assign lcg_next = seed_q * pps_pkg::LcgMul + pps_pkg::LcgInc;

  assign status_o.need_rand =
      ((op == pps_pkg::CmdTick) && tick_go && song_end && (mode_q == pps_pkg::ModeShuffle)) ||
      (((op == pps_pkg::CmdNext) || (op == pps_pkg::CmdPrev)) && !empty &&
       (mode_q == pps_pkg::ModeShuffle) && (cnt > CntW'(1)));
  assign status_o.need_mod =
      (op == pps_pkg::CmdTick) && tick_go && song_end && (mode_q == pps_pkg::ModeLoopAll);
  assign status_o.div_busy = div_busy;

  pps_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (div_src_q),
    .divisor_i  (cnt),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  always_comb begin
    st_d      = st_q;
    mode_d    = mode_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    vol_d     = vol_q;
    seed_d    = seed_q;
    div_src_d = div_src_q;
    jump_en   = 1'b0;
    jump_tgt  = '0;
    mem_we    = 1'b0;
    if (cmd_i.exec) begin
      unique case (op)
        pps_pkg::CmdTick: begin
          if (tick_go) begin
            if (!song_end) begin
              pos_d = pos_inc;
            end else begin
              case (mode_q)
                pps_pkg::ModeSeq: begin
                  if (idx9 == cnt_m1) begin
                    st_d  = pps_pkg::PlayStopped;
                    pos_d = pos_inc;
                  end else begin
                    jump_en  = 1'b1;
                    jump_tgt = inc9;
                  end
                end
                pps_pkg::ModeLoopAll: begin
                  div_src_d = {{(pps_pkg::SeedWidth-CntW){1'b0}}, inc9};
                end
                pps_pkg::ModeLoopOne: begin
                  pos_d = 16'd0;
                  st_d  = pps_pkg::PlayPlaying;
                end
                default: begin
                end
              endcase
            end
          end
        end
        pps_pkg::CmdPlay: begin
          if (!empty) begin
            jump_en  = 1'b1;
            jump_tgt = {1'b0, cmd_q.song_index};
          end
        end
        pps_pkg::CmdToggle: begin
          if (!empty) begin
            if (st_q == pps_pkg::PlayPlaying) begin
              st_d = pps_pkg::PlayPaused;
            end else begin
              if (pos_q >= rdata_q) begin
                pos_d = 16'd0;
              end
              st_d = pps_pkg::PlayPlaying;
            end
          end
        end
        pps_pkg::CmdNext: begin
          if (!empty && !status_o.need_rand) begin
            jump_en  = 1'b1;
            jump_tgt = (inc9 >= cnt) ? '0 : inc9;
          end
        end
        pps_pkg::CmdPrev: begin
          if (!empty && !status_o.need_rand) begin
            jump_en  = 1'b1;
            jump_tgt = (idx_q == 8'd0) ? cnt_m1 : dec9;
          end
        end
        pps_pkg::CmdCycle: begin
          mode_d = pps_pkg::play_mode_e'(mode_q + 2'd1);
        end
        pps_pkg::CmdVolume: begin
          vol_d = (cmd_q.volume_value > 8'd100) ? pps_pkg::VolumeMax
                                                : cmd_q.volume_value[6:0];
        end
        pps_pkg::CmdLoadDur: begin
          mem_we = {1'b0, cmd_q.song_index} < MaxCount;
        end
      endcase
    end
    if (cmd_i.lcg) begin
      seed_d    = lcg_next;
      div_src_d = lcg_next;
    end
    if (cmd_i.jump) begin
      jump_en  = 1'b1;
      jump_tgt = div_rem;
    end
    if (jump_en) begin
      idx_d = clamp_idx(jump_tgt, cnt);
      pos_d = 16'd0;
      st_d  = pps_pkg::PlayPlaying;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      st_q    <= pps_pkg::PlayIdle;
      mode_q  <= pps_pkg::ModeLoopAll;
      idx_q   <= 8'd0;
      pos_q   <= 16'd0;
      vol_q   <= pps_pkg::VolumeReset;
      seed_q  <= pps_pkg::SeedReset;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      st_q   <= st_d;
      mode_q <= mode_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      vol_q  <= vol_d;
      seed_q <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_src_q <= div_src_d;
    if (cmd_i.accept) begin
      cmd_q <= in_beat_i;
    end
    if (cmd_i.out_load) begin
      out_q.play_state       <= st_q;
      out_q.play_mode        <= mode_q;
      out_q.current_index    <= idx_q;
      out_q.position         <= pos_q;
      out_q.current_duration <= empty ? 16'd0 : rdata_q;
      out_q.volume           <= vol_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dur_mem[cmd_q.song_index[AddrWidth-1:0]] <= cmd_q.duration_value;
    end
    rdata_q <= dur_mem[idx_q[AddrWidth-1:0]];
  end

  assign out_beat_o = out_q;

endmodule

// ===== hdl/pps_ctrl.sv =====
// Controller of the playlist playback sequencer: one-hot state machine that
// sequences each command beat and owns the input and output handshakes.
// Depends on pps_pkg; commands pps_dp through ctrl_cmd_t.
module pps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  pps_pkg::dp_status_t status_i,
  output pps_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    SIdle     = 9'b000000001,
    SRead     = 9'b000000010,
    SExec     = 9'b000000100,
    SLcg      = 9'b000001000,
    SDivStart = 9'b000010000,
    SDiv      = 9'b000100000,
    SJump     = 9'b001000000,
    SReadOut  = 9'b010000000,
    SOut      = 9'b100000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  assign in_stall_o  = state_q != SIdle;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = SRead;
        end
      end
      SRead: begin
        state_d = SExec;
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        if (status_i.need_rand) begin
          state_d = SLcg;
        end else if (status_i.need_mod) begin
          state_d = SDivStart;
        end else begin
          state_d = SReadOut;
        end
      end
      SLcg: begin
        cmd_o.lcg = 1'b1;
        state_d   = SDivStart;
      end
      SDivStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = SDiv;
      end
      SDiv: begin
        if (!status_i.div_busy) begin
          state_d = SJump;
        end
      end
      SJump: begin
        cmd_o.jump = 1'b1;
        state_d    = SReadOut;
      end
      SReadOut: begin
        state_d = SOut;
      end
      SOut: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/playlist_playback_sequencer.sv =====
// Top level of the playlist playback sequencer.
// Joins the controller pps_ctrl and the datapath pps_dp; depends on pps_pkg.
//
// Each input beat is one command and gives exactly one output beat with the
// play state, mode, song index, position, duration and volume after it. A
// command is latched, the duration memory is read, the command is carried out,
// the memory is read again and the result is loaded into the output register;
// the input stalls meanwhile, so commands are taken one at a time. One that
// wraps the playlist at the end of a song, or jumps to a random song, also
// waits for the 32-step remainder divider that reduces the next index or the
// shuffle seed by the song count. The duration memory read is registered, so
// the current duration is fetched once before and once after the command is
// carried out. A finished result waits in an output register, so the next
// command is taken while it is still stalled; that command then waits for the
// register to empty. The duration memory holds NUM_SLOTS entries and has no
// reset; an entry must be loaded before its song is played. The song count
// must be written only while no command is in work; the block does not enforce it.
module playlist_playback_sequencer #(
  parameter int unsigned NUM_SLOTS = pps_pkg::MaxSongs
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pps_pkg::CountWidth-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pps_pkg::in_beat_t              in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pps_pkg::out_beat_t             out_beat_o
);

  pps_pkg::ctrl_cmd_t  cmd;
  pps_pkg::dp_status_t status;

  pps_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .status_i (status),
    .cmd_o    (cmd)
  );

  pps_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_beat_i,
    .cmd_i      (cmd),
    .status_o   (status),
    .out_beat_o
  );

endmodule

// ===== hdl/pps_checker.sv =====
// Port-level checks for the playlist playback sequencer.
// Depends on pps_pkg; bound to playlist_playback_sequencer below.
module pps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pps_pkg::out_beat_t out_beat_o
);

  // A command is worked on alone, so the input stalls right after a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_beat_o)))
    else $error("stalled output beat dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.volume <= pps_pkg::VolumeMax))
    else $error("volume above its limit");

  // The idle state is only left by starting a song or by a toggle, so it keeps song zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_beat_o.play_state == pps_pkg::PlayIdle)) |->
    ((out_beat_o.current_index == 8'd0) && (out_beat_o.position == 16'd0)))
    else $error("idle result with a song under way");

endmodule

bind playlist_playback_sequencer pps_checker u_pps_checker (.*);

// ===== tb/playlist_playback_sequencer_tb.sv =====
// Self-checking testbench for the playlist playback sequencer.
// A scoreboard class predicts the state after every command beat and compares results.
// Depends on pps_pkg and the playlist_playback_sequencer RTL only.
module playlist_playback_sequencer_tb;
  import pps_pkg::*;

  localparam int unsigned SongSlots    = 256;
  localparam logic [31:0] ShuffleMul   = 32'd1664525;
  localparam logic [31:0] ShuffleInc   = 32'd1013904223;
  localparam logic [31:0] ShuffleStart = 32'h12345678;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 50;
  localparam int unsigned PhaseBeats   = 90;
  localparam int unsigned NumPhases    = 12;

  class playback_scoreboard;
    logic [8:0]  song_count;
    play_state_e state;
    play_mode_e  mode;
    logic [7:0]  index;
    logic [15:0] position;
    logic [6:0]  volume;
    logic [31:0] seed;
    logic [15:0] durations [SongSlots];
    out_beat_t   pending_status[$];
    int unsigned mismatches;

    function new();
      song_count = '0;
      state = PlayIdle;
      mode = ModeLoopAll;
      index = '0;
      position = '0;
      volume = 7'd60;
      seed = ShuffleStart;
      mismatches = 0;
      foreach (durations[i]) durations[i] = '0;
    endfunction

    function int unsigned playable_songs();
      return (song_count > SongSlots) ? SongSlots : int'(song_count);
    endfunction

    function int unsigned outstanding();
      return pending_status.size();
    endfunction

    function void start_song(int unsigned target, int unsigned cnt);
      if (target >= cnt) target = cnt - 1;
      index = target[7:0];
      position = '0;
      state = PlayPlaying;
    endfunction

    function int unsigned shuffle_pick(int unsigned cnt);
      seed = seed * ShuffleMul + ShuffleInc;
      return seed % cnt;
    endfunction

    function void finish_song(int unsigned cnt);
      int unsigned cur;
      cur = index;
      case (mode)
        ModeSeq: begin
          if (cur == cnt - 1) state = PlayStopped;
          else start_song(cur + 1, cnt);
        end
        ModeLoopAll: start_song((cur + 1) % cnt, cnt);
        ModeLoopOne: begin
          position = '0;
          state = PlayPlaying;
        end
        default: start_song(shuffle_pick(cnt), cnt);
      endcase
    endfunction

    function void note_command(in_beat_t b);
      int unsigned cnt;
      int unsigned cur;
      int unsigned dur;
      out_beat_t   status;
      cnt = playable_songs();
      cur = index;
      case (cmd_e'(b.mode))
        CmdTick: begin
          if (cnt != 0 && state == PlayPlaying) begin
            dur = durations[index];
            if (dur != 0) begin
              if (position < dur) position = position + 16'd1;
              if (position >= dur) finish_song(cnt);
            end
          end
        end
        CmdPlay: if (cnt != 0) start_song(b.song_index, cnt);
        CmdToggle: begin
          if (cnt != 0) begin
            if (state == PlayPlaying) begin
              state = PlayPaused;
            end else begin
              if (position >= durations[index]) position = '0;
              state = PlayPlaying;
            end
          end
        end
        CmdNext: begin
          if (cnt != 0) begin
            if (mode == ModeShuffle && cnt > 1) start_song(shuffle_pick(cnt), cnt);
            else start_song((cur + 1 >= cnt) ? 0 : cur + 1, cnt);
          end
        end
        CmdPrev: begin
          if (cnt != 0) begin
            if (mode == ModeShuffle && cnt > 1) start_song(shuffle_pick(cnt), cnt);
            else start_song((cur == 0) ? cnt - 1 : cur - 1, cnt);
          end
        end
        CmdCycle: mode = play_mode_e'(mode + 2'd1);
        CmdVolume: volume = (b.volume_value > 8'd100) ? 7'd100 : b.volume_value[6:0];
        default: durations[b.song_index] = b.duration_value;
      endcase
      status.play_state       = state;
      status.play_mode        = mode;
      status.current_index    = index;
      status.position         = position;
      status.current_duration = (playable_songs() == 0) ? 16'd0 : durations[index];
      status.volume           = volume;
      pending_status.push_back(status);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        return;
      end
      want = pending_status.pop_front();
      compare_field("play_state", want.play_state, got.play_state);
      compare_field("play_mode", want.play_mode, got.play_mode);
      compare_field("current_index", want.current_index, got.current_index);
      compare_field("position", want.position, got.position);
      compare_field("current_duration", want.current_duration, got.current_duration);
      compare_field("volume", want.volume, got.volume);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CountWidth-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_beat_t              in_beat_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_beat_t             out_beat_o;

  playback_scoreboard sb;
  int unsigned        idle_mode;
  int unsigned        hold_left;
  int unsigned        cycle_count;

  playlist_playback_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 51;
      3: return $urandom_range(99) < 9;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      2: return $urandom_range(99) < 51;
      3: return $urandom_range(99) < 9;
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_beat_t command_beat(cmd_e op, logic [7:0] idx, logic [15:0] dur,
                                            logic [7:0] vol);
    in_beat_t b;
    b.mode = op;
    b.song_index = idx;
    b.duration_value = dur;
    b.volume_value = vol;
    return b;
  endfunction

  function automatic logic [15:0] random_duration();
    if ($urandom_range(19) == 0) return 16'($urandom);
    return 16'($urandom_range(6));
  endfunction

  function automatic in_beat_t random_command();
    in_beat_t    b;
    int unsigned pick;
    b = in_beat_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) b.mode = CmdTick;
    else if (pick < 58) b.mode = CmdPlay;
    else if (pick < 66) b.mode = CmdToggle;
    else if (pick < 73) b.mode = CmdNext;
    else if (pick < 80) b.mode = CmdPrev;
    else if (pick < 86) b.mode = CmdCycle;
    else if (pick < 92) b.mode = CmdVolume;
    else begin
      b.mode = CmdLoadDur;
      b.duration_value = random_duration();
    end
    return b;
  endfunction

  // Entered and left at a falling edge; valid stays high between back-to-back beats.
  task automatic send_command(in_beat_t b);
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(b);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic write_song_count(logic [CountWidth-1:0] value);
    wait_for_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.song_count = value;
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_stalls();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [CountWidth-1:0] phase_counts [NumPhases];
    phase_counts = '{9'd1, 9'd2, 9'd5, 9'd256, 9'd4, 9'd511,
                     9'd3, 9'd300, 9'd0, 9'd7, 9'd2, 9'd256};
    sb          = new();
    idle_mode   = 0;
    hold_left   = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_beat_i   = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty playlist: transport commands must leave everything untouched; mode, volume and duration loads still work.
    send_command(command_beat(CmdTick, 8'd0, 16'd0, 8'd0));
    send_command(command_beat(CmdPlay, 8'd255, 16'hffff, 8'hff));
    send_command(command_beat(CmdToggle, 8'd0, 16'd0, 8'd0));
    send_command(command_beat(CmdNext, 8'd0, 16'd0, 8'd0));
    send_command(command_beat(CmdPrev, 8'd0, 16'd0, 8'd0));
    repeat (4) send_command(command_beat(CmdCycle, 8'd0, 16'd0, 8'd0));
    send_command(command_beat(CmdVolume, 8'd0, 16'd0, 8'd0));
    send_command(command_beat(CmdVolume, 8'd0, 16'd0, 8'd100));
    send_command(command_beat(CmdVolume, 8'd0, 16'd0, 8'd101));
    send_command(command_beat(CmdVolume, 8'd0, 16'd0, 8'd255));
    send_command(command_beat(CmdLoadDur, 8'd0, 16'd0, 8'd0));
    send_command(command_beat(CmdLoadDur, 8'd255, 16'hffff, 8'd0));
    send_command(command_beat(CmdLoadDur, 8'd1, 16'd1, 8'd0));
    send_command(command_beat(CmdLoadDur, 8'd2, 16'd3, 8'd0));

    // Every song needs a duration before any count makes it reachable.
    idle_mode = 3;
    for (int unsigned i = 3; i < 255; i++) begin
      send_command(command_beat(CmdLoadDur, 8'(i), random_duration(), 8'($urandom)));
    end

    // Clamped play, wrap at the end of a song, a song of zero length and a pause.
    idle_mode = 0;
    write_song_count(9'd3);
    send_command(command_beat(CmdPlay, 8'd200, 16'd0, 8'd0));
    repeat (4) send_command(command_beat(CmdTick, 8'd0, 16'd0, 8'd0));
    send_command(command_beat(CmdPrev, 8'd0, 16'd0, 8'd0));
    repeat (2) send_command(command_beat(CmdToggle, 8'd0, 16'd0, 8'd0));

    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_song_count(phase_counts[p]);
      idle_mode = p % 4;
      if (p == 3) hold_left = 400;
      for (int unsigned i = 0; i < PhaseBeats; i++) begin
        if (p == 6 && i == PhaseBeats / 2) wait_for_results();
        send_command(random_command());
      end
    end

    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
